>>> rtl/rect_region_hit_table_macros.svh
// Assertion macros for the rect_region_hit_table project.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef RECT_REGION_HIT_TABLE_MACROS_SVH
`define RECT_REGION_HIT_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define RRHT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrht assertion failed");

// Next-cycle implication
`define RRHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrht assertion failed");

`else

`define RRHT_ASSERT_IMPL(lbl, ante, cons)
`define RRHT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/rrht_pkg.sv
// Shared types for the rectangle hit table: controller states and the
// command/status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rrht_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;        // capture the input request
        logic scan_start;  // rewind the entry walk
        logic scan;        // walk entries
        logic write;       // write the table entry
        logic append;      // write goes to a new entry at the count
        logic load_out;    // load the result register
        logic res_status;  // result: table full
        logic res_found;   // result: hit found
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;         // probed entry matches
        logic exhausted;   // all entries walked, none matched
        logic full;        // count equals table size
        logic is_hit_test; // captured request is a hit test
        logic out_free;    // result register can take a new result
    } sts_t;

endpackage

>>> rtl/rrht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/rrht_ctrl.sv
// Controller for the rectangle hit table: sequences capture, entry walk,
// table write and result hand-off. Depends on rrht_pkg.
`timescale 1ns / 1ps

module rrht_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rrht_pkg::sts_t sts,
    output rrht_pkg::cmd_t cmd
);

    rrht_pkg::state_t state_reg, state_next;
    logic found_reg, found_next;
    logic status_reg, status_next;
    logic append_reg, append_next;

    // State and result flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rrht_pkg::ST_IDLE;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            append_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            append_reg <= append_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        append_next    = append_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.res_status = status_reg;
        cmd.res_found  = found_reg;
        case (state_reg)
            rrht_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    found_next     = 1'b0;
                    status_next    = 1'b0;
                    append_next    = 1'b0;
                    state_next     = rrht_pkg::ST_SCAN;
                end
            end
            rrht_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.hit)
                begin
                    if (sts.is_hit_test)
                    begin
                        found_next = 1'b1;
                        state_next = rrht_pkg::ST_FINISH;
                    end
                    else
                    begin
                        append_next = 1'b0;
                        state_next  = rrht_pkg::ST_WRITE;
                    end
                end
                else if (sts.exhausted)
                begin
                    if (sts.is_hit_test)
                    begin
                        state_next = rrht_pkg::ST_FINISH;
                    end
                    else if (sts.full)
                    begin
                        status_next = 1'b1;
                        state_next  = rrht_pkg::ST_FINISH;
                    end
                    else
                    begin
                        append_next = 1'b1;
                        state_next  = rrht_pkg::ST_WRITE;
                    end
                end
            end
            rrht_pkg::ST_WRITE:
            begin
                cmd.write  = 1'b1;
                cmd.append = append_reg;
                state_next = rrht_pkg::ST_FINISH;
            end
            rrht_pkg::ST_FINISH:
            begin
                // Hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rrht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrht_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rrht_dp.sv
// Datapath for the rectangle hit table: request capture, entry count,
// pipelined entry walk over the table RAM, and the result register.
// Depends on rrht_pkg, rrht_ram and rect_region_hit_table_macros.svh.
`timescale 1ns / 1ps
`include "rect_region_hit_table_macros.svh"

module rrht_dp #(
    parameter int MAX_ENTRIES = 16,
    parameter int COORD_BITS  = 16,
    parameter int TAG_BITS    = 4,
    localparam int IN_W  = TAG_BITS + 4 * COORD_BITS,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 2 + TAG_BITS,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_func,
    input  logic [IN_TW-1:0]  in_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_TW-1:0] m_tdata,
    input  rrht_pkg::cmd_t    cmd,
    output rrht_pkg::sts_t    sts
);

    localparam int C      = COORD_BITS;
    localparam int T      = TAG_BITS;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Captured request
    logic             func_reg;
    logic [IN_W-1:0]  req_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             probe_valid_reg, probe_valid_next;
    logic [CNT_W-1:0] probe_idx_reg;
    logic [CNT_W-1:0] hit_idx_reg;
    logic [T-1:0]     hit_tag_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_TW-1:0] m_tdata_reg;

    logic [IN_W-1:0]   rd_data;
    logic [ADDR_W-1:0] wr_addr;
    logic              issue;
    logic              match;
    logic              hit;

    logic [T-1:0]        req_tag, ent_tag;
    logic signed [C-1:0] req_x, req_y, ent_left, ent_top, ent_wide, ent_tall;
    logic signed [C:0]   px, py, lft, top, rgt, bot;
    logic                in_rect;

    // Field views of the request and of the probed entry
    assign req_tag  = req_reg[T-1:0];
    assign req_x    = $signed(req_reg[T+C-1:T]);
    assign req_y    = $signed(req_reg[T+2*C-1:T+C]);
    assign ent_tag  = rd_data[T-1:0];
    assign ent_left = $signed(rd_data[T+C-1:T]);
    assign ent_top  = $signed(rd_data[T+2*C-1:T+C]);
    assign ent_wide = $signed(rd_data[T+3*C-1:T+2*C]);
    assign ent_tall = $signed(rd_data[T+4*C-1:T+3*C]);

    // Containment test, sums one bit wider than the coordinates
    assign px  = {req_x[C-1], req_x};
    assign py  = {req_y[C-1], req_y};
    assign lft = {ent_left[C-1], ent_left};
    assign top = {ent_top[C-1], ent_top};
    assign rgt = lft + {ent_wide[C-1], ent_wide};
    assign bot = top + {ent_tall[C-1], ent_tall};
    assign in_rect = (px >= lft) && (px < rgt) && (py >= top) && (py < bot);

    assign match = func_reg ? in_rect : (ent_tag == req_tag);
    assign hit   = probe_valid_reg && match;
    assign issue = cmd.scan && !hit && (idx_reg < count_reg);

    rrht_ram #(
        .WIDTH (IN_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (cmd.write),
        .wr_addr (wr_addr),
        .wr_data (req_reg),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Write to the matched entry, or append at the count
    assign wr_addr = cmd.append ? count_reg[ADDR_W-1:0] : hit_idx_reg[ADDR_W-1:0];

    // Walk, count and result handshake
    always_comb
    begin
        idx_next         = idx_reg;
        probe_valid_next = 1'b0;
        count_next       = count_reg;
        m_tvalid_next    = m_tvalid_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (issue)
        begin
            idx_next         = idx_reg + 1'b1;
            probe_valid_next = 1'b1;
        end
        if (cmd.write && cmd.append)
        begin
            count_next = count_reg + 1'b1;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            idx_reg         <= '0;
            probe_valid_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            probe_valid_reg <= probe_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= in_func;
            req_reg  <= in_data[IN_W-1:0];
        end
        if (issue)
        begin
            probe_idx_reg <= idx_reg;
        end
        if (cmd.scan && hit)
        begin
            hit_idx_reg <= probe_idx_reg;
            hit_tag_reg <= ent_tag;
        end
        if (cmd.load_out)
        begin
            m_tdata_reg <= OUT_TW'({(cmd.res_found ? hit_tag_reg : {T{1'b0}}),
                                    cmd.res_found, cmd.res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign sts.hit         = hit;
    assign sts.exhausted   = !probe_valid_reg && (idx_reg >= count_reg);
    assign sts.full        = (count_reg == CNT_W'(MAX_ENTRIES));
    assign sts.is_hit_test = func_reg;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    `RRHT_ASSERT_IMPL(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES))
    `RRHT_ASSERT_IMPL(a_probe_below_count, probe_valid_reg, probe_idx_reg < count_reg)
    `RRHT_ASSERT_NEXT(a_append_counts, cmd.write && cmd.append, count_reg == CNT_W'($past(count_reg) + 1'b1))
    `RRHT_ASSERT_IMPL(a_found_not_full, cmd.load_out, !(cmd.res_found && cmd.res_status))

endmodule

>>> rtl/rect_region_hit_table.sv
// Top level of the rectangle hit table: controller plus datapath.
// Depends on rrht_pkg, rrht_ctrl, rrht_dp (which holds rrht_ram).
`timescale 1ns / 1ps

// A table of up to MAX_ENTRIES tagged rectangles, one request at a time.
// s_tuser carries the function (0 write rectangle, 1 hit test point). A
// write updates the entry holding its tag or appends a new one; with the
// table full it returns status 1 and changes nothing. A hit test returns
// the tag of the first entry in insertion order that contains the point
// (left/top edges inclusive, right/bottom exclusive). The table is walked
// through one RAM read port at one entry per cycle; a finished request
// waits for m_tready while the result register still holds a result.
// s_tready is high only while no request is in work; a finished result may
// sit in the output register while the next request is taken.
module rect_region_hit_table #(
    parameter int MAX_ENTRIES = 16,
    parameter int COORD_BITS  = 16,
    parameter int TAG_BITS    = 4,
    localparam int IN_TW  = ((TAG_BITS + 4 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TW = ((2 + TAG_BITS + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // region_tag, coord_x, coord_y, rect_width, rect_height, zero pad
    input  logic [IN_TW-1:0]  s_tdata,
    // func
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // status, hit_found, hit_tag, zero pad
    output logic [OUT_TW-1:0] m_tdata
);

    rrht_pkg::cmd_t cmd;
    rrht_pkg::sts_t sts;

    rrht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrht_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_func  (s_tuser),
        .in_data  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

>>> tb/tb.sv
// Self-checking bench for rect_region_hit_table: directed and random write and
// hit-test requests, checked against a copy of the table held in the bench.
// Depends on the rect_region_hit_table RTL only.
`timescale 1ns / 1ps

module tb;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_HIT    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int TABLE_SIZE       = 16;
    localparam int NUM_PHASES       = 4;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int DIR_ROWS         = 19;
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 40;

    typedef struct packed {
        logic               func;
        logic [3:0]         tag;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] wide;
        logic signed [15:0] tall;
    } region_req_t;

    typedef struct packed {
        logic       status;
        logic       found;
        logic [3:0] tag;
    } region_res_t;

    typedef struct packed {
        region_req_t req;
        logic        typed;
        region_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // Bench copy of the rectangle table
    logic [3:0]         shadow_tag  [TABLE_SIZE];
    logic signed [15:0] shadow_left [TABLE_SIZE];
    logic signed [15:0] shadow_top  [TABLE_SIZE];
    logic signed [15:0] shadow_wide [TABLE_SIZE];
    logic signed [15:0] shadow_tall [TABLE_SIZE];
    int                 shadow_count = 0;

    region_res_t pending_results [$];
    dir_row_t    dir_rows [DIR_ROWS];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int n_writes       = 0;
    int n_probes       = 0;
    int n_found        = 0;
    int idle_cycles    = 0;

    rect_region_hit_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the bench table and return its result
    function automatic region_res_t apply_region_request(region_req_t r);
        region_res_t res  = '0;
        int          slot = -1;
        int          px   = $signed(r.x);
        int          py   = $signed(r.y);
        res.status = STATUS_OK;
        if (r.func == FUNC_WRITE)
        begin
            for (int i = 0; i < shadow_count; i++)
                if (slot < 0 && shadow_tag[i] == r.tag)
                    slot = i;
            if (slot < 0 && shadow_count < TABLE_SIZE)
            begin
                slot = shadow_count;
                shadow_tag[slot] = r.tag;
                shadow_count++;
            end
            if (slot < 0)
                res.status = STATUS_FULL;
            else
            begin
                shadow_left[slot] = r.x;
                shadow_top[slot]  = r.y;
                shadow_wide[slot] = r.wide;
                shadow_tall[slot] = r.tall;
            end
        end
        else
        begin
            // Walk backward so the earliest matching entry wins
            for (int i = shadow_count - 1; i >= 0; i--)
                if (px >= shadow_left[i] && px < shadow_left[i] + shadow_wide[i] &&
                    py >= shadow_top[i] && py < shadow_top[i] + shadow_tall[i])
                begin
                    res.found = 1'b1;
                    res.tag   = shadow_tag[i];
                end
        end
        return res;
    endfunction

    function automatic dir_row_t dir_row(logic func, int tag, int x, int y, int wide,
                                         int tall, logic typed = 1'b0,
                                         logic found = 1'b0, int hit_tag = 0);
        dir_row_t row = '0;
        row.req.func   = func;
        row.req.tag    = 4'(tag);
        row.req.x      = 16'(x);
        row.req.y      = 16'(y);
        row.req.wide   = 16'(wide);
        row.req.tall   = 16'(tall);
        row.typed      = typed;
        row.res.status = STATUS_OK;
        row.res.found  = found;
        row.res.tag    = 4'(hit_tag);
        return row;
    endfunction

    // Pick a coordinate on or just beside the edges of a span, or inside it
    function automatic logic [15:0] near_span(int lo, int span);
        case ($urandom_range(4))
            0: return 16'(lo - 1);
            1: return 16'(lo);
            2: return 16'(lo + span - 1);
            3: return 16'(lo + span);
            default: return 16'(lo + int'($urandom_range(span > 1 ? span - 1 : 0)));
        endcase
    endfunction

    function automatic logic [15:0] random_size();
        case ($urandom_range(9))
            0: return 16'(-int'($urandom_range(3)));
            1: return 16'($urandom);
            default: return 16'($urandom_range(400, 1));
        endcase
    endfunction

    function automatic region_req_t random_region_request();
        region_req_t r;
        int          k;
        r.func = ($urandom_range(99) < 40) ? FUNC_WRITE : FUNC_HIT;
        r.tag  = 4'($urandom_range(15));
        r.x    = 16'($urandom);
        r.y    = 16'($urandom);
        r.wide = 16'($urandom);
        r.tall = 16'($urandom);
        if (r.func == FUNC_WRITE)
        begin
            // Mostly small rectangles clustered near the origin so that they overlap
            if ($urandom_range(9) != 0)
            begin
                r.x = 16'(int'($urandom_range(1200)) - 600);
                r.y = 16'(int'($urandom_range(1200)) - 600);
            end
            r.wide = random_size();
            r.tall = random_size();
        end
        else if (shadow_count > 0 && $urandom_range(9) < 7)
        begin
            // Probe around a stored rectangle
            k   = $urandom_range(shadow_count - 1);
            r.x = near_span(shadow_left[k], shadow_wide[k]);
            r.y = near_span(shadow_top[k], shadow_tall[k]);
        end
        else if ($urandom_range(9) < 7)
        begin
            r.x = 16'(int'($urandom_range(1400)) - 700);
            r.y = 16'(int'($urandom_range(1400)) - 700);
        end
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its result
    task automatic send_region_request(region_req_t r, logic typed, region_res_t typed_res);
        region_res_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {4'b0, r.tall, r.wide, r.y, r.x, r.tag};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = apply_region_request(r);
        if (r.func == FUNC_WRITE)
            n_writes++;
        else
            n_probes++;
        if (want.found)
            n_found++;
        pending_results.push_back(typed ? typed_res : want);
    endtask

    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Take results and compare them with the oldest expectation
    initial
    begin
        region_res_t got;
        region_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.status = m_tdata[0];
                got.found  = m_tdata[1];
                got.tag    = m_tdata[5:2];
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("hit_found", want.found, got.found);
                    compare_field("hit_tag", want.tag, got.tag);
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Abort when neither side has moved a request for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_results.size());
            $display("[rect_region_hit_table] ERROR");
            $finish;
        end
    end

    initial
    begin
        // Each tag fits in the table, so no write in this table ever sees it full
        dir_rows = '{
            // empty table: no hit, unused fields at both extremes
            dir_row(FUNC_HIT,    0,      0,      0,      0,      0, 1'b1, 1'b0, 0),
            dir_row(FUNC_HIT,   15, -32768,  32767, -32768, -32768, 1'b1, 1'b0, 0),
            // most negative corner, widest span: right and bottom edges excluded
            dir_row(FUNC_WRITE,  0, -32768, -32768,  32767,  32767, 1'b1),
            dir_row(FUNC_HIT,    0, -32768, -32768,      0,      0, 1'b1, 1'b1, 0),
            dir_row(FUNC_HIT,    0,     -1,     -1,      0,      0, 1'b1, 1'b0, 0),
            dir_row(FUNC_HIT,    0,     -2,     -1,      0,      0, 1'b1, 1'b0, 0),
            dir_row(FUNC_HIT,    0,     -2,     -2,      0,      0, 1'b1, 1'b1, 0),
            // most positive corner: edge sums must not wrap
            dir_row(FUNC_WRITE, 15,  32767,  32767,  32767,  32767, 1'b1),
            dir_row(FUNC_HIT,    0,  32767,  32767,      0,      0, 1'b1, 1'b1, 15),
            // zero and negative sizes give rectangles that no point hits
            dir_row(FUNC_WRITE,  3,      0,      0,      0,      5, 1'b1),
            dir_row(FUNC_WRITE,  4,      0,      0, -32768, -32768, 1'b1),
            dir_row(FUNC_HIT,    0,      0,      0,      0,      0, 1'b1, 1'b0, 0),
            // update in place keeps the entry's slot in insertion order
            dir_row(FUNC_WRITE,  3,      0,      0,     10,     10, 1'b1),
            dir_row(FUNC_WRITE,  5,   -100,   -100,    200,    200, 1'b1),
            dir_row(FUNC_HIT,    0,      5,      5,      0,      0, 1'b1, 1'b1, 3),
            dir_row(FUNC_HIT,   15,     10,      9,     -1,     -1),
            dir_row(FUNC_HIT,    7,   -100,     99,  32767,      1),
            dir_row(FUNC_WRITE,  5,     -1,     -1,      1,      1),
            dir_row(FUNC_HIT,    0,     -1,     -1,      0,      0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phases: no idling, sender idle, receiver stalling, both a little
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            if (phase == 0)
                foreach (dir_rows[i])
                    send_region_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            repeat (RANDOM_PER_PHASE)
                send_region_request(random_region_request(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d writes and %0d hit tests (%0d matched), table at %0d entries,",
                 n_writes, n_probes, n_found, shadow_count);
        $display("across four sender/receiver idling phases; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("[rect_region_hit_table] OK");
        else
            $display("[rect_region_hit_table] ERROR");
        $finish;
    end

endmodule
